>>> hdl/fpc_pkg.sv
// ----------------------------------------------------------------------------
// Fixed-point converter package
// Shared payload and pipeline stage types, widths and opcodes for the
// fixed-point format converter.
// ----------------------------------------------------------------------------
`default_nettype none

package fpc_pkg;

  localparam int unsigned XW = 64;
  localparam int unsigned IW = 6;
  localparam int unsigned FW = 7;
  localparam int unsigned WW = 8;

  localparam logic [FW-1:0] FB_MAX = 7'd64;

  localparam logic OP_FIX = 1'b0;
  localparam logic OP_INT = 1'b1;

  typedef struct packed {
    logic          opcode;
    logic [XW-1:0] src_bits;
    logic          src_signed;
    logic [IW-1:0] src_ibit;
    logic [FW-1:0] src_fbit;
    logic          dst_signed;
    logic [IW-1:0] dst_ibit;
    logic [FW-1:0] dst_fbit;
    logic          saturate;
  } fpc_in_t;

  typedef struct packed {
    logic [XW-1:0] result_bits;
    logic          overflow;
  } fpc_out_t;

  typedef struct packed {
    logic          pass;
    logic          neg;
    logic          d_sgn;
    logic          sat;
    logic [FW-1:0] k;
    logic [FW-1:0] ifb;
    logic [WW-1:0] w;
  } fpc_ctl_t;

  typedef struct packed {
    fpc_ctl_t      ctl;
    logic          rshift;
    logic [FW-1:0] r;
    logic [XW-1:0] m;
  } fpc_s1_t;

  typedef struct packed {
    fpc_ctl_t      ctl;
    logic          rnd;
    logic [XW-1:0] m;
  } fpc_s2_t;

  typedef struct packed {
    fpc_ctl_t      ctl;
    logic [XW-1:0] m;
  } fpc_s3_t;

  typedef struct packed {
    fpc_ctl_t      ctl;
    logic          nz;
    logic          pow2;
    logic [FW-1:0] bl;
    logic [XW-1:0] res;
  } fpc_s4_t;

  typedef struct packed {
    fpc_ctl_t      ctl;
    logic          over_hi;
    logic          over_lo;
    logic [XW-1:0] res;
  } fpc_s5_t;

endpackage

`default_nettype wire

>>> hdl/fpc_prep.sv
// ----------------------------------------------------------------------------
// Fixed-point converter input stage
// Extends the source, splits it into sign and magnitude and works out the
// shift direction and amount and the destination width.
// ----------------------------------------------------------------------------
`default_nettype none

module fpc_prep
  import fpc_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  fpc_in_t in_item,
  output logic    s1_valid,
  output fpc_s1_t s1
);

  localparam logic [XW-1:0] DMASK = {XW{1'b1}} >> (XW - DATA_WIDTH);

  logic [XW-1:0] v;
  logic [FW-1:0] sfc;
  logic [FW-1:0] dfc;
  logic          same;
  logic          neg;
  fpc_s1_t       s1_next;

  always_comb begin
    v = in_item.src_bits & DMASK;
    if (in_item.src_signed && in_item.src_bits[DATA_WIDTH-1]) begin
      v = v | ~DMASK;
    end
    sfc = (in_item.src_fbit > FB_MAX) ? FB_MAX : in_item.src_fbit;
    dfc = (in_item.dst_fbit > FB_MAX) ? FB_MAX : in_item.dst_fbit;
    same = (in_item.opcode == OP_FIX) && (in_item.src_signed == in_item.dst_signed) &&
           (in_item.src_ibit == in_item.dst_ibit) && (in_item.src_fbit == in_item.dst_fbit);
    neg = in_item.src_signed && v[XW-1];

    s1_next.ctl.pass  = same;
    s1_next.ctl.d_sgn = in_item.dst_signed;
    s1_next.ctl.sat   = in_item.saturate;
    s1_next.ctl.ifb   = {1'b0, in_item.dst_ibit} + dfc;
    s1_next.ctl.w     = {1'b0, s1_next.ctl.ifb} + WW'(in_item.dst_signed);
    s1_next.ctl.neg   = neg;
    s1_next.ctl.k     = '0;
    s1_next.rshift    = 1'b0;
    s1_next.r         = '0;
    s1_next.m         = neg ? (XW'(0) - v) : v;

    if (same) begin
      s1_next.ctl.neg = 1'b0;
      s1_next.m       = v;
    end else if (in_item.opcode == OP_INT) begin
      s1_next.ctl.k = dfc;
    end else if (dfc >= sfc) begin
      s1_next.ctl.k = dfc - sfc;
    end else begin
      s1_next.rshift = 1'b1;
      s1_next.r      = sfc - dfc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
    s1 <= s1_next;
  end

endmodule

`default_nettype wire

>>> hdl/fpc_align.sv
// ----------------------------------------------------------------------------
// Fixed-point converter alignment stages
// Right-shifts the magnitude when fraction bits are dropped, then rounds a
// negative value's magnitude up so that the result truncates toward minus
// infinity.
// ----------------------------------------------------------------------------
`default_nettype none

module fpc_align
  import fpc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s1_valid,
  input  fpc_s1_t s1,
  output logic    s3_valid,
  output fpc_s3_t s3
);

  logic          s2_valid;
  fpc_s2_t       s2;
  fpc_s2_t       s2_next;
  fpc_s3_t       s3_next;
  logic [XW-1:0] low_mask;

  always_comb begin
    low_mask    = ~({XW{1'b1}} << s1.r[5:0]);
    s2_next.ctl = s1.ctl;
    s2_next.m   = s1.m;
    s2_next.rnd = 1'b0;
    if (s1.rshift) begin
      if (s1.r[6]) begin
        s2_next.m   = '0;
        s2_next.rnd = s1.ctl.neg;
      end else begin
        s2_next.m   = s1.m >> s1.r[5:0];
        s2_next.rnd = s1.ctl.neg && ((s1.m & low_mask) != '0);
      end
    end
  end

  always_comb begin
    s3_next.ctl = s2.ctl;
    s3_next.m   = s2.m + XW'(s2.rnd);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
    s2 <= s2_next;
    s3 <= s3_next;
  end

endmodule

`default_nettype wire

>>> hdl/fpc_range.sv
// ----------------------------------------------------------------------------
// Fixed-point converter range stages
// Finds the leading one and scales the magnitude, then checks the exact
// value against the destination range and applies the sign.
// ----------------------------------------------------------------------------
`default_nettype none

module fpc_range
  import fpc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s3_valid,
  input  fpc_s3_t s3,
  output logic    s5_valid,
  output fpc_s5_t s5
);

  logic          s4_valid;
  fpc_s4_t       s4;
  fpc_s4_t       s4_next;
  fpc_s5_t       s5_next;
  logic [WW-1:0] sum;
  logic [WW-1:0] ifb1;
  logic          lo_cond;

  always_comb begin
    s4_next.ctl  = s3.ctl;
    s4_next.nz   = (s3.m != '0);
    s4_next.pow2 = ((s3.m & (s3.m - XW'(1))) == '0);
    s4_next.bl   = '0;
    for (int i = 0; i < XW; i++) begin
      if (s3.m[i]) begin
        s4_next.bl = FW'(i + 1);
      end
    end
    s4_next.res = s3.ctl.k[6] ? '0 : (s3.m << s3.ctl.k[5:0]);
  end

  always_comb begin
    sum     = {1'b0, s4.bl} + {1'b0, s4.ctl.k};
    ifb1    = {1'b0, s4.ctl.ifb} + WW'(1);
    lo_cond = !s4.ctl.d_sgn || (sum > ifb1) || ((sum == ifb1) && !s4.pow2);
    s5_next.ctl     = s4.ctl;
    s5_next.over_hi = !s4.ctl.pass && s4.nz && !s4.ctl.neg && (sum > {1'b0, s4.ctl.ifb});
    s5_next.over_lo = !s4.ctl.pass && s4.nz && s4.ctl.neg && lo_cond;
    s5_next.res     = s4.ctl.neg ? (XW'(0) - s4.res) : s4.res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
    end
    s4 <= s4_next;
    s5 <= s5_next;
  end

  // A value is never above and below the destination range at once.
  a_over_excl: assert property (@(posedge clk) disable iff (rst)
    s5_valid |-> !(s5.over_hi && s5.over_lo))
    else $error("fpc_range: both range violations flagged");

endmodule

`default_nettype wire

>>> hdl/fpc_pack.sv
// ----------------------------------------------------------------------------
// Fixed-point converter output stage
// Selects the pass-through value, the saturation bound or the wrapped value
// extended from the destination width; registers the result and its strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module fpc_pack
  import fpc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     s5_valid,
  input  fpc_s5_t  s5,
  output logic     done,
  output fpc_out_t result
);

  logic [XW-1:0] hi_bound;
  logic [XW-1:0] lo_bound;
  logic [XW-1:0] ext_mask;
  logic [XW-1:0] ext;
  logic          top_bit;
  fpc_out_t      result_next;

  always_comb begin
    hi_bound = s5.ctl.ifb[6] ? {XW{1'b1}} : ((XW'(1) << s5.ctl.ifb[5:0]) - XW'(1));
    lo_bound = (!s5.ctl.d_sgn || s5.ctl.ifb[6]) ? '0 : (XW'(0) - (XW'(1) << s5.ctl.ifb[5:0]));
    ext_mask = ~({XW{1'b1}} << s5.ctl.w[5:0]);
    top_bit  = s5.res[s5.ctl.w[5:0] - 6'd1];
    if (s5.ctl.w[7] || s5.ctl.w[6]) begin
      ext = s5.res;
    end else if (s5.ctl.w == '0) begin
      ext = '0;
    end else if (s5.ctl.d_sgn && top_bit) begin
      ext = s5.res | ~ext_mask;
    end else begin
      ext = s5.res & ext_mask;
    end

    result_next.overflow = 1'b0;
    priority if (s5.ctl.pass) begin
      result_next.result_bits = s5.res;
    end else if (s5.over_hi && s5.ctl.sat) begin
      result_next.result_bits = hi_bound;
    end else if (s5.over_lo && s5.ctl.sat) begin
      result_next.result_bits = lo_bound;
    end else begin
      result_next.result_bits = ext;
      result_next.overflow    = s5.over_hi || s5.over_lo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s5_valid;
    end
    result <= result_next;
  end

  // Saturating conversions clamp instead of reporting overflow.
  a_sat_no_ovf: assert property (@(posedge clk) disable iff (rst)
    (s5_valid && s5.ctl.sat) |=> !result.overflow)
    else $error("fpc_pack: overflow reported while saturating");

  // An unchanged format passes the value through without overflow.
  a_pass_no_ovf: assert property (@(posedge clk) disable iff (rst)
    (s5_valid && s5.ctl.pass) |=> (!result.overflow && result.result_bits == $past(s5.res)))
    else $error("fpc_pack: pass-through value altered");

endmodule

`default_nettype wire

>>> hdl/fixed_point_format_converter_top.sv
// ----------------------------------------------------------------------------
// Fixed-point format converter
// Converts fixed-point or integer values into a destination fixed-point
// format with optional saturation.
// ----------------------------------------------------------------------------
// The converter takes one transaction in every clock cycle and never raises
// busy. Each result appears on result with done high for exactly one cycle,
// in the order the transactions were issued; the receiver must take it in
// that cycle. Each transaction passes through six register stages: input
// decode and sign split, the right shifter, the rounding adder, leading-one
// detection with the left shifter, the range compare with sign restore, and
// the output select.
`default_nettype none

module fixed_point_format_converter_top
  import fpc_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  fpc_in_t  item,
  output logic     done,
  output fpc_out_t result
);

  logic    in_valid;
  logic    s1_valid;
  logic    s3_valid;
  logic    s5_valid;
  fpc_s1_t s1;
  fpc_s3_t s3;
  fpc_s5_t s5;

  assign busy     = 1'b0;
  assign in_valid = start && !busy;

  fpc_prep #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_prep (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_item (item),
    .s1_valid(s1_valid),
    .s1      (s1)
  );

  fpc_align u_align (
    .clk     (clk),
    .rst     (rst),
    .s1_valid(s1_valid),
    .s1      (s1),
    .s3_valid(s3_valid),
    .s3      (s3)
  );

  fpc_range u_range (
    .clk     (clk),
    .rst     (rst),
    .s3_valid(s3_valid),
    .s3      (s3),
    .s5_valid(s5_valid),
    .s5      (s5)
  );

  fpc_pack u_pack (
    .clk     (clk),
    .rst     (rst),
    .s5_valid(s5_valid),
    .s5      (s5),
    .done    (done),
    .result  (result)
  );

  // Every accepted transaction produces its result with done high.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid |-> ##6 done)
    else $error("fixed_point_format_converter_top: result missing");

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// Fixed-point format converter testbench
// Drives conversion transactions into the converter with random sender gaps.
// A scoreboard predicts every result from the accepted transaction and
// compares it, in order, with what the block returns.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top
  import fpc_pkg::*;
();

  localparam int unsigned DW        = 64;
  localparam int unsigned CYCLE_CAP = 200000;
  localparam int unsigned N_RANDOM  = 1500;

  class conversion_scoreboard;
    fpc_out_t expected_q[$];
    int       errors;
    int       checked;
    int       wrapped;

    function automatic int unsigned bit_length(logic [63:0] m);
      int unsigned bl;
      bl = 0;
      for (int i = 0; i < 64; i++) begin
        if (m[i]) bl = i + 1;
      end
      return bl;
    endfunction

    function automatic logic [63:0] extend(logic [63:0] v, int unsigned w, logic sgn);
      logic [63:0] mask;
      if (w >= 64) return v;
      if (w == 0) return 64'd0;
      mask = (64'd1 << w) - 64'd1;
      v = v & mask;
      if (sgn && v[w-1]) v = v | ~mask;
      return v;
    endfunction

    function automatic fpc_out_t convert(fpc_in_t x);
      logic [63:0] dmask, v, m, res, frac;
      logic        neg, over_hi, over_lo, ovf;
      int unsigned sfc, dfc, ifb, w, k, r, bl;
      fpc_out_t    y;
      dmask = {64{1'b1}} >> (64 - DW);
      v = x.src_bits & dmask;
      if (x.src_signed && v[DW-1]) v = v | ~dmask;
      if (x.opcode == OP_FIX && x.src_signed == x.dst_signed &&
          x.src_ibit == x.dst_ibit && x.src_fbit == x.dst_fbit) begin
        y.result_bits = v;
        y.overflow    = 1'b0;
        return y;
      end
      sfc = (x.src_fbit > FB_MAX) ? 64 : x.src_fbit;
      dfc = (x.dst_fbit > FB_MAX) ? 64 : x.dst_fbit;
      ifb = x.dst_ibit + dfc;
      w   = ifb + (x.dst_signed ? 1 : 0);
      neg = x.src_signed && v[63];
      m   = neg ? (64'd0 - v) : v;
      k   = 0;
      if (x.opcode == OP_INT) begin
        k = dfc;
      end else if (dfc >= sfc) begin
        k = dfc - sfc;
      end else begin
        r = sfc - dfc;
        if (!neg) begin
          m = (r >= 64) ? 64'd0 : (m >> r);
        end else if (r >= 64) begin
          m = 64'd1;
        end else begin
          frac = m & ((64'd1 << r) - 64'd1);
          m = (m >> r) + ((frac != 64'd0) ? 64'd1 : 64'd0);
        end
      end
      over_hi = 1'b0;
      over_lo = 1'b0;
      if (m != 64'd0) begin
        bl = bit_length(m);
        if (!neg) begin
          over_hi = (bl + k) > ifb;
        end else if (!x.dst_signed) begin
          over_lo = 1'b1;
        end else if (bl + k - 1 > ifb) begin
          over_lo = 1'b1;
        end else if (bl + k - 1 == ifb) begin
          over_lo = (m != (64'd1 << (bl - 1)));
        end
      end
      ovf = 1'b0;
      if (over_hi && x.saturate) begin
        res = (ifb >= 64) ? {64{1'b1}} : ((64'd1 << ifb) - 64'd1);
      end else if (over_lo && x.saturate) begin
        if (!x.dst_signed) res = 64'd0;
        else res = (ifb >= 64) ? 64'd0 : (64'd0 - (64'd1 << ifb));
      end else begin
        ovf = over_hi || over_lo;
        res = (k >= 64) ? 64'd0 : (m << k);
        if (neg) res = 64'd0 - res;
        res = extend(res, w, x.dst_signed);
      end
      y.result_bits = res;
      y.overflow    = ovf;
      return y;
    endfunction

    function void note_item(fpc_in_t x);
      expected_q.push_back(convert(x));
    endfunction

    function void check_result(fpc_out_t act);
      fpc_out_t exp_r;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, no transaction pending: bits %h ovf %b",
                 $time, act.result_bits, act.overflow);
        return;
      end
      exp_r = expected_q.pop_front();
      checked++;
      if (exp_r.overflow) wrapped++;
      if (exp_r.result_bits !== act.result_bits) begin
        errors++;
        $display("%0t: result_bits mismatch: expected %h actual %h",
                 $time, exp_r.result_bits, act.result_bits);
      end
      if (exp_r.overflow !== act.overflow) begin
        errors++;
        $display("%0t: overflow mismatch: expected %b actual %b",
                 $time, exp_r.overflow, act.overflow);
      end
    endfunction
  endclass

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  fpc_in_t  item;
  logic     done;
  fpc_out_t result;

  conversion_scoreboard sb;
  int unsigned          cycles = 0;
  int                   n_directed;

  fixed_point_format_converter_top #(.DATA_WIDTH(DW)) dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("fixed_point_format_converter_top verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_item(item);
      if (done) sb.check_result(result);
    end
  end

  function automatic fpc_in_t make_item(logic op, logic [63:0] bits, logic ssg,
                                        int sib, int sfb, logic dsg, int dib,
                                        int dfb, logic sat);
    fpc_in_t x;
    x.opcode     = op;
    x.src_bits   = bits;
    x.src_signed = ssg;
    x.src_ibit   = IW'(sib);
    x.src_fbit   = FW'(sfb);
    x.dst_signed = dsg;
    x.dst_ibit   = IW'(dib);
    x.dst_fbit   = FW'(dfb);
    x.saturate   = sat;
    return x;
  endfunction

  function automatic int rand_fbit();
    int sel;
    sel = $urandom_range(19);
    if (sel < 2) return $urandom_range(127, 65);
    if (sel < 4) return 64;
    if (sel < 12) return $urandom_range(16);
    return $urandom_range(64);
  endfunction

  function automatic int rand_ibit();
    if ($urandom_range(1)) return $urandom_range(12);
    return $urandom_range(63);
  endfunction

  function automatic fpc_in_t rand_item();
    fpc_in_t     x;
    logic [63:0] bits;
    int unsigned small_v;
    case ($urandom_range(5))
      0: bits = {$urandom, $urandom};
      1: begin
        small_v = $urandom_range(511);
        bits = $urandom_range(1) ? (64'd0 - 64'(small_v)) : 64'(small_v);
      end
      2: begin
        case ($urandom_range(4))
          0: bits = 64'd0;
          1: bits = 64'd1;
          2: bits = {64{1'b1}};
          3: bits = 64'h8000_0000_0000_0000;
          default: bits = 64'h7FFF_FFFF_FFFF_FFFF;
        endcase
      end
      3: begin
        bits = 64'd1 << $urandom_range(63);
        if ($urandom_range(1)) bits = 64'd0 - bits;
      end
      default: begin
        bits = {$urandom, $urandom} >> $urandom_range(63);
        if ($urandom_range(1)) bits = ~bits;
      end
    endcase
    x = make_item($urandom_range(1), bits, $urandom_range(1), rand_ibit(), rand_fbit(),
                  $urandom_range(1), rand_ibit(), rand_fbit(), $urandom_range(1));
    if ($urandom_range(99) < 12) begin
      x.opcode     = OP_FIX;
      x.dst_signed = x.src_signed;
      x.dst_ibit   = x.src_ibit;
      x.dst_fbit   = x.src_fbit;
    end
    return x;
  endfunction

  task automatic drive_item(input fpc_in_t x, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    item  <= x;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic run_directed();
    fpc_in_t d[$];
    d.push_back(make_item(OP_FIX, {64{1'b1}}, 1, 3, 4, 1, 3, 4, 0));
    d.push_back(make_item(OP_FIX, 64'h1234_5678_9ABC_DEF0, 0, 10, 5, 0, 10, 5, 1));
    d.push_back(make_item(OP_FIX, 64'd5, 1, 2, 2, 1, 4, 6, 0));
    d.push_back(make_item(OP_FIX, 64'd0 - 64'd5, 1, 4, 4, 1, 4, 1, 0));
    d.push_back(make_item(OP_FIX, {64{1'b1}}, 1, 0, 64, 1, 0, 0, 0));
    d.push_back(make_item(OP_FIX, 64'h7FFF_FFFF_FFFF_FFFF, 0, 0, 64, 0, 0, 0, 1));
    d.push_back(make_item(OP_FIX, {64{1'b1}}, 1, 63, 0, 0, 8, 0, 1));
    d.push_back(make_item(OP_FIX, {64{1'b1}}, 1, 63, 0, 0, 8, 0, 0));
    d.push_back(make_item(OP_FIX, 64'h7FFF_FFFF_FFFF_FFFF, 0, 63, 0, 1, 7, 0, 1));
    d.push_back(make_item(OP_FIX, 64'h7FFF_FFFF_FFFF_FFFF, 0, 63, 0, 1, 7, 0, 0));
    d.push_back(make_item(OP_FIX, 64'h8000_0000_0000_0000, 1, 63, 0, 1, 7, 0, 1));
    d.push_back(make_item(OP_FIX, 64'd0 - 64'd128, 1, 63, 0, 1, 7, 0, 0));
    d.push_back(make_item(OP_FIX, 64'd0 - 64'd129, 1, 63, 0, 1, 7, 0, 0));
    d.push_back(make_item(OP_INT, 64'd0 - 64'd3, 1, 0, 0, 1, 8, 4, 0));
    d.push_back(make_item(OP_INT, {64{1'b1}}, 0, 0, 0, 0, 63, 64, 1));
    d.push_back(make_item(OP_INT, {64{1'b1}}, 0, 0, 0, 0, 4, 2, 1));
    d.push_back(make_item(OP_INT, 64'd0, 0, 0, 0, 0, 0, 0, 0));
    d.push_back(make_item(OP_INT, 64'd1, 0, 0, 0, 0, 0, 0, 0));
    d.push_back(make_item(OP_FIX, 64'hDEAD_BEEF_0123_4567, 1, 5, 127, 1, 5, 100, 0));
    d.push_back(make_item(OP_FIX, 64'hFFFF_0000_FFFF_0000, 1, 1, 65, 1, 20, 0, 1));
    d.push_back(make_item(OP_FIX, 64'h8000_0000_0000_0000, 1, 0, 0, 1, 63, 64, 0));
    d.push_back(make_item(OP_FIX, 64'd0, 1, 7, 3, 1, 2, 9, 1));
    d.push_back(make_item(OP_INT, 64'h8000_0000_0000_0000, 1, 0, 0, 1, 63, 0, 1));
    d.push_back(make_item(OP_INT, 64'h0000_0000_0000_00FF, 1, 8, 3, 1, 8, 3, 0));
    foreach (d[i]) drive_item(d[i], (i % 3 == 0) ? 50 : 0);
    n_directed = d.size();
  endtask

  initial begin
    sb     = new();
    rst   <= 1'b1;
    start <= 1'b0;
    item  <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    for (int i = 0; i < N_RANDOM; i++) begin
      drive_item(rand_item(), (i < N_RANDOM / 3) ? 35 : (i < 2 * N_RANDOM / 3) ? 64 : 0);
    end
    start <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (sb.expected_q.size() != 0) sb.errors++;
    $display("Checked %0d conversions (%0d directed, %0d random) from both opcodes,",
             sb.checked, n_directed, N_RANDOM);
    $display("with %0d wrapped overflows and %0d mismatches.", sb.wrapped, sb.errors);
    if (sb.errors == 0) begin
      $display("fixed_point_format_converter_top verification clean");
    end else begin
      $display("fixed_point_format_converter_top verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
hdl/fpc_pkg.sv
hdl/fpc_prep.sv
hdl/fpc_align.sv
hdl/fpc_range.sv
hdl/fpc_pack.sv
hdl/fixed_point_format_converter_top.sv
tb/tb_top.sv
